// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the escaper checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define XCE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define XCE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication, always on
`define XCE_ASSERT_NXT_ANY(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/xce_pkg.sv -----
// ----------------------------------------------------------------------------
// xce_pkg
// types and constants shared by the xml character escaper modules
// ----------------------------------------------------------------------------
package xce_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int UNIT_W     = 16;
    localparam int LEN_W      = 4;
    localparam int IDX_W      = 3;
    localparam int NDIG_W     = 3;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_QUOTE_EN   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEWLINE_EN = 8'd1;

    localparam logic [UNIT_W-1:0] CH_AMP   = 16'h0026;
    localparam logic [UNIT_W-1:0] CH_LT    = 16'h003C;
    localparam logic [UNIT_W-1:0] CH_GT    = 16'h003E;
    localparam logic [UNIT_W-1:0] CH_QUOT  = 16'h0022;
    localparam logic [UNIT_W-1:0] CH_CR    = 16'h000D;
    localparam logic [UNIT_W-1:0] CH_LF    = 16'h000A;
    localparam logic [UNIT_W-1:0] CH_HASH  = 16'h0023;
    localparam logic [UNIT_W-1:0] CH_X     = 16'h0078;
    localparam logic [UNIT_W-1:0] CH_SEMI  = 16'h003B;
    localparam logic [UNIT_W-1:0] CH_A     = 16'h0061;
    localparam logic [UNIT_W-1:0] CH_M     = 16'h006D;
    localparam logic [UNIT_W-1:0] CH_P     = 16'h0070;
    localparam logic [UNIT_W-1:0] CH_L     = 16'h006C;
    localparam logic [UNIT_W-1:0] CH_G     = 16'h0067;
    localparam logic [UNIT_W-1:0] CH_T     = 16'h0074;
    localparam logic [UNIT_W-1:0] CH_Q     = 16'h0071;
    localparam logic [UNIT_W-1:0] CH_U     = 16'h0075;
    localparam logic [UNIT_W-1:0] CH_O     = 16'h006F;
    localparam logic [UNIT_W-1:0] CH_NBSP  = 16'h00A0;
    localparam logic [UNIT_W-1:0] SP_FIRST = 16'h2002;
    localparam logic [UNIT_W-1:0] SP_LAST  = 16'h200B;
    localparam logic [UNIT_W-1:0] SP_SKIP  = 16'h2006;
    localparam logic [UNIT_W-1:0] SP_MATH  = 16'h205F;

    typedef enum logic [2:0] {
        CLS_PASS,
        CLS_AMP,
        CLS_LT,
        CLS_GT,
        CLS_QUOT,
        CLS_HEX
    } cls_t;

    typedef struct packed {
        cls_t              cls;
        logic [UNIT_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic [NDIG_W-1:0] ndig;
    } item_t;

endpackage

// ----- rtl/core/xce_fifo.sv -----
// ----------------------------------------------------------------------------
// xce_fifo
// short queue of classified items between the front and the back end
// ----------------------------------------------------------------------------
module xce_fifo #(
    parameter int DEPTH = xce_pkg::FIFO_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           wr_valid,
    input  xce_pkg::item_t wr_item,
    output logic           full,
    output logic           rd_valid,
    output xce_pkg::item_t rd_item,
    input  logic           rd_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    xce_pkg::item_t mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_wr, do_rd;

    assign full     = (count_reg == FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && !full;
    assign do_rd    = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CW'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ----- rtl/core/xce_front.sv -----
// ----------------------------------------------------------------------------
// xce_front
// accepts input beats, holds the config switches and classifies each unit
// ----------------------------------------------------------------------------
module xce_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [xce_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [xce_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [xce_pkg::UNIT_W-1:0]         s_code_unit,
    output logic                               push_valid,
    output xce_pkg::item_t                     push_item,
    input  logic                               fifo_full
);

    logic quote_en_reg, quote_en_next;
    logic nl_en_reg, nl_en_next;
    logic listed;
    logic [xce_pkg::UNIT_W-1:0] c;

    assign cfg_ready  = 1'b1;
    assign s_ready    = !fifo_full;
    assign push_valid = s_valid;
    assign c          = s_code_unit;

    always_comb begin
        quote_en_next = quote_en_reg;
        nl_en_next    = nl_en_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                xce_pkg::REG_QUOTE_EN:   quote_en_next = cfg_data[0];
                xce_pkg::REG_NEWLINE_EN: nl_en_next    = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quote_en_reg <= 1'b0;
            nl_en_reg    <= 1'b0;
        end else begin
            quote_en_reg <= quote_en_next;
            nl_en_reg    <= nl_en_next;
        end
    end

    assign listed = (c == xce_pkg::CH_NBSP) || (c == xce_pkg::SP_MATH) ||
                    ((c >= xce_pkg::SP_FIRST) && (c <= xce_pkg::SP_LAST) &&
                     (c != xce_pkg::SP_SKIP));

    always_comb begin
        push_item.code = c;
        push_item.cls  = xce_pkg::CLS_PASS;
        push_item.len  = xce_pkg::LEN_W'(1);
        push_item.ndig = xce_pkg::NDIG_W'(1);
        if (c == xce_pkg::CH_AMP) begin
            push_item.cls = xce_pkg::CLS_AMP;
            push_item.len = xce_pkg::LEN_W'(5);
        end else if (c == xce_pkg::CH_LT) begin
            push_item.cls = xce_pkg::CLS_LT;
            push_item.len = xce_pkg::LEN_W'(4);
        end else if (c == xce_pkg::CH_GT) begin
            push_item.cls = xce_pkg::CLS_GT;
            push_item.len = xce_pkg::LEN_W'(4);
        end else if (listed) begin
            push_item.cls = xce_pkg::CLS_HEX;
            if (c == xce_pkg::CH_NBSP) begin
                push_item.ndig = xce_pkg::NDIG_W'(2);
                push_item.len  = xce_pkg::LEN_W'(6);
            end else begin
                push_item.ndig = xce_pkg::NDIG_W'(4);
                push_item.len  = xce_pkg::LEN_W'(8);
            end
        end else if (quote_en_reg && (c == xce_pkg::CH_QUOT)) begin
            push_item.cls = xce_pkg::CLS_QUOT;
            push_item.len = xce_pkg::LEN_W'(6);
        end else if (nl_en_reg && ((c == xce_pkg::CH_CR) || (c == xce_pkg::CH_LF))) begin
            push_item.cls  = xce_pkg::CLS_HEX;
            push_item.ndig = xce_pkg::NDIG_W'(1);
            push_item.len  = xce_pkg::LEN_W'(5);
        end
    end

endmodule

// ----- rtl/core/xce_back.sv -----
// ----------------------------------------------------------------------------
// xce_back
// walks queued items into the output reg one unit per cycle, unless stalled
// ----------------------------------------------------------------------------
module xce_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       rd_valid,
    input  xce_pkg::item_t             rd_item,
    output logic                       rd_pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [xce_pkg::UNIT_W-1:0] m_out_unit,
    output logic                       m_run_end
);

    function automatic logic [xce_pkg::UNIT_W-1:0] hex_char(input logic [3:0] nib);
        logic [xce_pkg::UNIT_W-1:0] n16;
        n16 = {12'h000, nib};
        return (nib < 4'd10) ? (16'h0030 + n16) : (16'h0057 + n16);
    endfunction

    function automatic logic [xce_pkg::UNIT_W-1:0] unit_at(
        input xce_pkg::item_t          it,
        input logic [xce_pkg::IDX_W-1:0] idx
    );
        logic [xce_pkg::UNIT_W-1:0] u;
        logic [xce_pkg::IDX_W-1:0]  j;
        logic [xce_pkg::NDIG_W-1:0] dsel;
        logic [3:0]                 nib;
        u    = xce_pkg::CH_SEMI;
        j    = idx - xce_pkg::IDX_W'(3);
        dsel = it.ndig - xce_pkg::NDIG_W'(1) - xce_pkg::NDIG_W'(j);
        case (dsel[1:0])
            2'd0:    nib = it.code[3:0];
            2'd1:    nib = it.code[7:4];
            2'd2:    nib = it.code[11:8];
            default: nib = it.code[15:12];
        endcase
        case (it.cls)
            xce_pkg::CLS_PASS: u = it.code;
            xce_pkg::CLS_AMP: begin
                case (idx)
                    3'd0:    u = xce_pkg::CH_AMP;
                    3'd1:    u = xce_pkg::CH_A;
                    3'd2:    u = xce_pkg::CH_M;
                    3'd3:    u = xce_pkg::CH_P;
                    default: u = xce_pkg::CH_SEMI;
                endcase
            end
            xce_pkg::CLS_LT: begin
                case (idx)
                    3'd0:    u = xce_pkg::CH_AMP;
                    3'd1:    u = xce_pkg::CH_L;
                    3'd2:    u = xce_pkg::CH_T;
                    default: u = xce_pkg::CH_SEMI;
                endcase
            end
            xce_pkg::CLS_GT: begin
                case (idx)
                    3'd0:    u = xce_pkg::CH_AMP;
                    3'd1:    u = xce_pkg::CH_G;
                    3'd2:    u = xce_pkg::CH_T;
                    default: u = xce_pkg::CH_SEMI;
                endcase
            end
            xce_pkg::CLS_QUOT: begin
                case (idx)
                    3'd0:    u = xce_pkg::CH_AMP;
                    3'd1:    u = xce_pkg::CH_Q;
                    3'd2:    u = xce_pkg::CH_U;
                    3'd3:    u = xce_pkg::CH_O;
                    3'd4:    u = xce_pkg::CH_T;
                    default: u = xce_pkg::CH_SEMI;
                endcase
            end
            xce_pkg::CLS_HEX: begin
                if (idx == 3'd0) begin
                    u = xce_pkg::CH_AMP;
                end else if (idx == 3'd1) begin
                    u = xce_pkg::CH_HASH;
                end else if (idx == 3'd2) begin
                    u = xce_pkg::CH_X;
                end else if (xce_pkg::NDIG_W'(j) < it.ndig) begin
                    u = hex_char(nib);
                end else begin
                    u = xce_pkg::CH_SEMI;
                end
            end
            default: u = it.code;
        endcase
        return u;
    endfunction

    xce_pkg::item_t               cur_reg, cur_next;
    logic                         cur_valid_reg, cur_valid_next;
    logic [xce_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic                         out_valid_reg, out_valid_next;
    logic [xce_pkg::UNIT_W-1:0]   out_unit_reg, out_unit_next;
    logic                         out_end_reg, out_end_next;
    logic                         emit, is_last;

    assign emit    = cur_valid_reg && (!out_valid_reg || m_ready);
    assign is_last = ({1'b0, idx_reg} == (cur_reg.len - xce_pkg::LEN_W'(1)));
    assign rd_pop  = rd_valid && (!cur_valid_reg || (emit && is_last));

    assign m_valid    = out_valid_reg;
    assign m_out_unit = out_unit_reg;
    assign m_run_end  = out_end_reg;

    always_comb begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (rd_pop) begin
            cur_next       = rd_item;
            cur_valid_next = 1'b1;
            idx_next       = '0;
        end else if (emit && is_last) begin
            cur_valid_next = 1'b0;
        end else if (emit) begin
            idx_next = idx_reg + xce_pkg::IDX_W'(1);
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_unit_next  = out_unit_reg;
        out_end_next   = out_end_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_unit_next  = unit_at(cur_reg, idx_reg);
            out_end_next   = is_last;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        out_unit_reg <= out_unit_next;
        out_end_reg  <= out_end_next;
    end

endmodule

// ----- rtl/core/xml_character_escaper.sv -----
// ----------------------------------------------------------------------------
// xml_character_escaper
// escapes a utf-16 stream for xml text, one input unit to a run of 1 to 8 units
// ----------------------------------------------------------------------------
// a beat goes through the queue and the current-item register to the output
// throughput: one output beat per cycle while m_ready is high, from the single
//   back-end emit unit; a passed unit is one beat, an escape its run length
// the 4-entry queue lets input beats keep flowing while an escape is emitted
// reset: synchronous, clears both config switches, the queue and the output
module xml_character_escaper #(
    parameter int FIFO_DEPTH = xce_pkg::FIFO_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [xce_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [xce_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [xce_pkg::UNIT_W-1:0]     s_code_unit,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [xce_pkg::UNIT_W-1:0]     m_out_unit,
    output logic                           m_run_end
);

    logic           push_valid;
    xce_pkg::item_t push_item;
    logic           fifo_full;
    logic           rd_valid;
    xce_pkg::item_t rd_item;
    logic           rd_pop;

    xce_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_unit (s_code_unit),
        .push_valid  (push_valid),
        .push_item   (push_item),
        .fifo_full   (fifo_full)
    );

    xce_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_item  (push_item),
        .full     (fifo_full),
        .rd_valid (rd_valid),
        .rd_item  (rd_item),
        .rd_pop   (rd_pop)
    );

    xce_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_valid   (rd_valid),
        .rd_item    (rd_item),
        .rd_pop     (rd_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_unit (m_out_unit),
        .m_run_end  (m_run_end)
    );

endmodule

// ----- rtl/core/xce_checker.sv -----
// ----------------------------------------------------------------------------
// xce_checker
// port-level checks on the escaper output stream, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xce_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       cfg_valid,
    input logic                       cfg_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [xce_pkg::UNIT_W-1:0] m_out_unit,
    input logic                       m_run_end
);

    logic                     inner_beat;
    logic                     amp_or_end;
    logic                     stalled;
    logic [xce_pkg::UNIT_W:0] out_word;

    assign inner_beat = m_valid && !m_run_end;
    assign amp_or_end = m_run_end || (m_out_unit == xce_pkg::CH_AMP);
    assign stalled    = m_valid && !m_ready;
    assign out_word   = {m_out_unit, m_run_end};

    // output register is empty right after reset
    `XCE_ASSERT_NXT_ANY(a_reset_empties_out, aclk, !aresetn, !m_valid)

    `XCE_ASSERT_IMP(a_cfg_always_ready, aclk, aresetn, cfg_valid, cfg_ready)

    // only escape sequences have inner beats, and those are plain ascii
    `XCE_ASSERT_IMP(a_inner_beat_ascii, aclk, aresetn, inner_beat, m_out_unit[15:8] == 8'h00)

    // a multi-beat run opens with an ampersand
    `XCE_ASSERT_NXT(a_run_opens_amp, aclk, aresetn, m_valid && m_ready && m_run_end, !m_valid || amp_or_end)

    `XCE_ASSERT_NXT(a_out_beat_holds, aclk, aresetn, stalled, m_valid && $stable(out_word))

endmodule

bind xml_character_escaper xce_checker u_xce_checker (.*);

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking testbench for xml_character_escaper: drives utf-16 units
// under random source gaps and sink stalls, predicts each escaped run, and
// compares every output beat against it while stepping through switch settings
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic [xce_pkg::UNIT_W-1:0] out_unit;
        logic                       run_end;
    } esc_beat_t;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [xce_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [xce_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           s_valid;
    logic                           s_ready;
    logic [xce_pkg::UNIT_W-1:0]     s_code_unit;
    logic                           m_valid;
    logic                           m_ready;
    logic [xce_pkg::UNIT_W-1:0]     m_out_unit;
    logic                           m_run_end;

    esc_beat_t escaped_q[$];
    bit        quote_on;
    bit        newline_on;
    bit        src_idle_on;
    bit        sink_idle_on;
    int        err_cnt;
    int        units_sent;
    int        beats_seen;
    int        esc_runs;
    int        cfg_writes;

    xml_character_escaper dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code_unit (s_code_unit),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_unit  (m_out_unit),
        .m_run_end   (m_run_end)
    );

    always #2 aclk = ~aclk;

    function automatic int gap_len();
        if ($urandom_range(9) == 0) return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    // expected run for one code unit under the current switches
    function automatic void predict_escape(input logic [xce_pkg::UNIT_W-1:0] c);
        logic [xce_pkg::UNIT_W-1:0] run[$];
        logic [xce_pkg::UNIT_W-1:0] digit;
        logic [3:0]                 d;
        bit                         started;
        bit                         listed;
        esc_beat_t                  b;
        started = 0;
        listed  = (c == xce_pkg::CH_NBSP) || (c == xce_pkg::SP_MATH) ||
                  ((c >= xce_pkg::SP_FIRST) && (c <= xce_pkg::SP_LAST) &&
                   (c != xce_pkg::SP_SKIP));
        if (c == xce_pkg::CH_AMP) begin
            run = '{xce_pkg::CH_AMP, xce_pkg::CH_A, xce_pkg::CH_M, xce_pkg::CH_P,
                    xce_pkg::CH_SEMI};
        end else if (c == xce_pkg::CH_LT) begin
            run = '{xce_pkg::CH_AMP, xce_pkg::CH_L, xce_pkg::CH_T, xce_pkg::CH_SEMI};
        end else if (c == xce_pkg::CH_GT) begin
            run = '{xce_pkg::CH_AMP, xce_pkg::CH_G, xce_pkg::CH_T, xce_pkg::CH_SEMI};
        end else if (quote_on && c == xce_pkg::CH_QUOT) begin
            run = '{xce_pkg::CH_AMP, xce_pkg::CH_Q, xce_pkg::CH_U, xce_pkg::CH_O,
                    xce_pkg::CH_T, xce_pkg::CH_SEMI};
        end else if (listed
                     || (newline_on && (c == xce_pkg::CH_CR || c == xce_pkg::CH_LF))) begin
            run = '{xce_pkg::CH_AMP, xce_pkg::CH_HASH, xce_pkg::CH_X};
            for (int sh = 12; sh >= 0; sh -= 4) begin
                d = c[sh +: 4];
                if (d != 0 || started || sh == 0) begin
                    started = 1;
                    digit = (d < 4'd10) ? 16'h0030 + {12'h000, d}
                                        : xce_pkg::CH_A + {12'h000, d - 4'd10};
                    run.push_back(digit);
                end
            end
            run.push_back(xce_pkg::CH_SEMI);
        end else begin
            run = '{c};
        end
        foreach (run[i]) begin
            b.out_unit = run[i];
            b.run_end  = (i == run.size() - 1);
            escaped_q.push_back(b);
        end
        if (run.size() > 1) esc_runs++;
    endfunction

    // random text, weighted toward escapes and their neighbors
    function automatic logic [xce_pkg::UNIT_W-1:0] pick_unit();
        logic [xce_pkg::UNIT_W-1:0] marks[6];
        marks = '{xce_pkg::CH_AMP, xce_pkg::CH_LT, xce_pkg::CH_GT, xce_pkg::CH_QUOT,
                  xce_pkg::CH_CR, xce_pkg::CH_LF};
        case ($urandom_range(9))
            0, 1, 2, 3: return xce_pkg::UNIT_W'($urandom());
            4:          return xce_pkg::UNIT_W'($urandom_range(16'h7F));
            5:          return xce_pkg::UNIT_W'(xce_pkg::SP_FIRST - 2 + $urandom_range(13));
            6:          return xce_pkg::UNIT_W'(xce_pkg::SP_MATH - 3 + $urandom_range(6));
            7:          return xce_pkg::UNIT_W'(xce_pkg::CH_NBSP - 3 + $urandom_range(6));
            default:    return marks[$urandom_range(5)];
        endcase
    endfunction

    // sends one unit; starts and ends on a falling edge
    task automatic send_unit(input logic [xce_pkg::UNIT_W-1:0] c);
        s_valid     <= 1'b1;
        s_code_unit <= c;
        do @(posedge aclk); while (!s_ready);
        predict_escape(c);
        units_sent++;
        @(negedge aclk);
        if (src_idle_on && $urandom_range(2) == 0) begin
            s_valid <= 1'b0;
            repeat (gap_len()) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (escaped_q.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic write_switch(input logic [xce_pkg::CFG_IDX_W-1:0] idx,
                                input logic [xce_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == xce_pkg::REG_QUOTE_EN) quote_on = val[0];
        else if (idx == xce_pkg::REG_NEWLINE_EN) newline_on = val[0];
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // switches at reset: quote and newlines pass through
    task automatic test_reset_state();
        send_unit(16'h0000);
        send_unit(16'hFFFF);
        send_unit(xce_pkg::CH_QUOT);
        send_unit(xce_pkg::CH_CR);
        send_unit(xce_pkg::CH_LF);
        wait_drained();
    endtask

    task automatic test_markup_and_spaces();
        logic [xce_pkg::UNIT_W-1:0] list[13];
        list = '{xce_pkg::CH_AMP, xce_pkg::CH_LT, xce_pkg::CH_GT, xce_pkg::CH_NBSP,
                 16'h2001, xce_pkg::SP_FIRST, 16'h2005, xce_pkg::SP_SKIP, 16'h2007,
                 xce_pkg::SP_LAST, 16'h200C, xce_pkg::SP_MATH, 16'hD800};
        foreach (list[i]) send_unit(list[i]);
        wait_drained();
    endtask

    // only bit 0 counts; unknown indexes are ignored
    task automatic test_config_switches();
        write_switch(xce_pkg::REG_QUOTE_EN, 8'hFF);
        write_switch(xce_pkg::REG_NEWLINE_EN, 8'h01);
        write_switch(8'hFF, 8'h00);
        write_switch(8'h02, 8'hFE);
        send_unit(xce_pkg::CH_QUOT);
        send_unit(xce_pkg::CH_CR);
        send_unit(xce_pkg::CH_LF);
        wait_drained();
        write_switch(xce_pkg::REG_NEWLINE_EN, 8'hFE);
        send_unit(xce_pkg::CH_LF);
        send_unit(xce_pkg::CH_QUOT);
        wait_drained();
        write_switch(xce_pkg::REG_QUOTE_EN, 8'h00);
        send_unit(xce_pkg::CH_QUOT);
        wait_drained();
    endtask

    task automatic test_random_text();
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_on  = (ph != 0);
            sink_idle_on = (ph != 0);
            write_switch(xce_pkg::REG_QUOTE_EN, {7'($urandom()), ph[0]});
            write_switch(xce_pkg::REG_NEWLINE_EN, {7'($urandom()), ph[1]});
            write_switch(8'($urandom_range(255, 2)), 8'($urandom()));
            for (int i = 0; i < 70; i++) begin
                send_unit(pick_unit());
                // source holds off until every run is out
                if (ph == 2 && i % 23 == 22) wait_drained();
            end
            wait_drained();
        end
    endtask

    // sink stalls
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_idle_on && $urandom_range(3) == 0) begin
                m_ready <= 1'b0;
                repeat (gap_len()) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        esc_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            beats_seen++;
            if (escaped_q.size() == 0) begin
                $error("unexpected beat: out_unit %h run_end %b", m_out_unit, m_run_end);
                err_cnt++;
            end else begin
                want = escaped_q.pop_front();
                if (m_out_unit !== want.out_unit) begin
                    $error("out_unit: expected %h, got %h", want.out_unit, m_out_unit);
                    err_cnt++;
                end
                if (m_run_end !== want.run_end) begin
                    $error("run_end: expected %b, got %b", want.run_end, m_run_end);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("tb failed");
        $finish;
    end

    initial begin
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_code_unit  = '0;
        src_idle_on  = 1;
        sink_idle_on = 1;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_state();
        test_markup_and_spaces();
        test_config_switches();
        test_random_text();
        wait_drained();

        $display("sent %0d code units, checked %0d output beats (%0d escaped runs)",
                 units_sent, beats_seen, esc_runs);
        $display("made %0d switch writes, all four quote/newline settings",
                 cfg_writes);
        if (err_cnt == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/xce_pkg.sv
rtl/core/xce_fifo.sv
rtl/core/xce_front.sv
rtl/core/xce_back.sv
rtl/core/xml_character_escaper.sv
rtl/core/xce_checker.sv
tb/tb.sv
